/* rtl/ofgp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofgp_pkg: shared types and constants of the gradient product block
// Register indexes, result widths, queue sizing and the flag group that
// travels with every beat from the front end to the multiplier back end.
// ----------------------------------------------------------------------------
package ofgp_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  // Geometry register widths and reset values.
  localparam int unsigned FW_W = 11;
  localparam int unsigned FH_W = 16;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1024;
  localparam logic [FH_W-1:0] MIN_HEIGHT = 16'd3;

  // Result field widths.
  localparam int unsigned XX_W = 18;
  localparam int unsigned XY_W = 19;
  localparam int unsigned YY_W = 18;
  localparam int unsigned XT_W = 18;
  localparam int unsigned YT_W = 18;
  localparam int unsigned OUT_FIELDS_W = XX_W + XY_W + YY_W + XT_W + YT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Queue between front end and back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Flags carried with each beat.
  typedef struct packed {
    logic out_valid;
    logic frame_last;
  } ofgp_flags_t;

endpackage

/* rtl/ofgp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofgp_ram: generic single-port RAM
// One access per cycle; the read data is registered and returns the
// contents from before a write to the same address (read-first).
// ----------------------------------------------------------------------------
module ofgp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first access.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/ofgp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofgp_queue: short first-in first-out queue
// Decouples the pixel front end from the multiplier back end. The head
// entry is presented without delay whenever the queue is not empty.
// ----------------------------------------------------------------------------
module ofgp_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [WIDTH-1:0]            wdata,
  input  logic                        pop,
  output logic [WIDTH-1:0]            rdata,
  output logic                        rvalid,
  output logic [ofgp_pkg::QUEUE_AW:0] count
);

  localparam int unsigned AW = ofgp_pkg::QUEUE_AW;

  logic [WIDTH-1:0] entries [ofgp_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

  assign rdata  = entries[rptr];
  assign rvalid = (count != '0);

endmodule

/* rtl/ofgp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofgp_front: raster tracking, line stores and difference stage
// Accepts pixel pairs, tracks the raster position, keeps two lines of both
// frames and forms the summed x and y differences and the temporal
// difference of the pixel one line and one pixel behind the input.
// ----------------------------------------------------------------------------
module ofgp_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned IN_W       = 16,
  parameter int unsigned QDW        = 29
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ofgp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ofgp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [IN_W-1:0]                     s_tdata,
  input  logic [ofgp_pkg::QUEUE_AW:0]         q_count,
  output logic                                q_push,
  output ofgp_pkg::ofgp_flags_t               q_flags,
  output logic [QDW-1:0]                      q_data
);

  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = PB + 2;
  localparam int unsigned DW = PB + 1;
  localparam int unsigned FH = ofgp_pkg::FH_W;

  logic [ofgp_pkg::FW_W-1:0] frame_width;
  logic [FH-1:0]             frame_height;
  logic [CW-1:0]             col;
  logic [FH-1:0]             row;
  logic                      frame_seen;
  logic [WW-1:0]             fill0;
  logic [WW-1:0]             fill1;

  logic [WW-1:0]   w_eff;
  logic [FH-1:0]   h_eff;
  logic [WW-1:0]   col_inc;
  logic [FH:0]     row_inc;
  logic            accept;
  logic            slot;
  logic            in_frame;
  logic            interior;
  ofgp_pkg::ofgp_flags_t flags;
  logic [2*PB-1:0] pix;
  logic [2*PB-1:0] rd0;
  logic [2*PB-1:0] rd1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ofgp_pkg::FRAME_WIDTH_RST;
      frame_height <= ofgp_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ofgp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[ofgp_pkg::FW_W-1:0];
        ofgp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[FH-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: width limited to the line store, both at least three.
  always_comb begin
    if (32'(frame_width) < 32'd3) begin
      w_eff = WW'(3);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height < ofgp_pkg::MIN_HEIGHT) ? ofgp_pkg::MIN_HEIGHT : frame_height;
  end

  // Classification of the beat at the current raster position.
  always_comb begin
    col_inc  = {1'b0, col} + 1'b1;
    row_inc  = {1'b0, row} + 1'b1;
    slot     = row[0];
    in_frame = (row >= FH'(2)) || ((row == FH'(1)) && (col != '0));
    interior = in_frame && (col >= CW'(2)) && ({1'b0, col} < w_eff) &&
               (row >= FH'(2)) && (row < h_eff);
    flags.out_valid  = in_frame || frame_seen;
    flags.frame_last = !in_frame && frame_seen && (row == FH'(1)) && (col == '0);
    pix = s_tdata[2*PB-1:0];
  end

  logic s1_valid;

  // Room is reserved in the queue for the beat in the difference stage.
  assign s_tready = (32'(q_count) + 32'(s1_valid)) < ofgp_pkg::QUEUE_DEPTH;
  assign accept   = s_tvalid && s_tready;

  // Raster counters and per-slot fill counts (written columns form a prefix).
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      frame_seen <= 1'b0;
      fill0      <= '0;
      fill1      <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col <= '0;
        if (row_inc >= {1'b0, h_eff}) begin
          row        <= '0;
          frame_seen <= 1'b1;
        end else begin
          row <= row_inc[FH-1:0];
        end
      end else begin
        col <= col_inc[CW-1:0];
      end
      if (!slot && (col_inc > fill0)) begin
        fill0 <= col_inc;
      end
      if (slot && (col_inc > fill1)) begin
        fill1 <= col_inc;
      end
    end
  end

  // Line stores, one per row parity, both frames side by side.
  ofgp_ram #(.WIDTH(2 * PB), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .en    (accept),
    .we    (accept && !slot),
    .addr  (col),
    .wdata (pix),
    .rdata (rd0)
  );

  ofgp_ram #(.WIDTH(2 * PB), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .en    (accept),
    .we    (accept && slot),
    .addr  (col),
    .wdata (pix),
    .rdata (rd1)
  );

  // Stage one: beat information that lines up with the store read data.
  ofgp_pkg::ofgp_flags_t s1_flags;
  logic                  s1_interior;
  logic                  s1_slot;
  logic                  s1_rv0;
  logic                  s1_rv1;
  logic [2*PB-1:0]       s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags    <= flags;
      s1_interior <= interior;
      s1_slot     <= slot;
      s1_rv0      <= ({1'b0, col} < fill0);
      s1_rv1      <= ({1'b0, col} < fill1);
      s1_pix      <= pix;
    end
  end

  // Window: previous-row taps, the old current-row entry and the last pixel.
  logic [2*PB-1:0] tap1;
  logic [2*PB-1:0] tap2;
  logic [2*PB-1:0] win;
  logic [2*PB-1:0] prev_pix;
  logic [2*PB-1:0] m0;
  logic [2*PB-1:0] m1;
  logic [2*PB-1:0] cur_old;
  logic [2*PB-1:0] prv_val;

  always_comb begin
    m0      = s1_rv0 ? rd0 : '0;
    m1      = s1_rv1 ? rd1 : '0;
    cur_old = s1_slot ? m1 : m0;
    prv_val = s1_slot ? m0 : m1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap1     <= '0;
      tap2     <= '0;
      win      <= '0;
      prev_pix <= '0;
    end else if (s1_valid) begin
      tap2     <= tap1;
      tap1     <= prv_val;
      win      <= cur_old;
      prev_pix <= s1_pix;
    end
  end

  // Differences: right minus left, below minus above, later minus earlier.
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic signed [DW-1:0] dt;

  always_comb begin
    sx = '0;
    sy = '0;
    dt = '0;
    if (s1_interior) begin
      sx = $signed({2'b00, prv_val[PB-1:0]}) - $signed({2'b00, tap2[PB-1:0]}) +
           $signed({2'b00, prv_val[2*PB-1:PB]}) - $signed({2'b00, tap2[2*PB-1:PB]});
      sy = $signed({2'b00, prev_pix[PB-1:0]}) - $signed({2'b00, win[PB-1:0]}) +
           $signed({2'b00, prev_pix[2*PB-1:PB]}) - $signed({2'b00, win[2*PB-1:PB]});
      dt = $signed({1'b0, tap1[2*PB-1:PB]}) - $signed({1'b0, tap1[PB-1:0]});
    end
  end

  assign q_push  = s1_valid;
  assign q_flags = s1_flags;
  assign q_data  = {sx, sy, dt};

endmodule

/* rtl/ofgp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofgp_back: product stage and output register
// Pops one queue entry whenever the output register is free or being
// taken, forms the five products and holds the result beat.
// ----------------------------------------------------------------------------
module ofgp_back #(
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned QDW        = 29
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  ofgp_pkg::ofgp_flags_t                q_flags,
  input  logic [QDW-1:0]                       q_data,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ofgp_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  output logic                                 m_tuser
);

  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned SW = PB + 2;
  localparam int unsigned DW = PB + 1;
  localparam int unsigned PW = 2 * SW;
  localparam int unsigned EW = (PW > ofgp_pkg::XY_W) ? PW : ofgp_pkg::XY_W;
  localparam int unsigned PAD = ofgp_pkg::OUT_DATA_W - ofgp_pkg::OUT_FIELDS_W;

  logic signed [SW-1:0]      sx;
  logic signed [SW-1:0]      sy;
  logic signed [DW-1:0]      dt;
  logic signed [PW-1:0]      p_xx;
  logic signed [PW-1:0]      p_xy;
  logic signed [PW-1:0]      p_yy;
  logic signed [SW+DW-1:0]   p_xt;
  logic signed [SW+DW-1:0]   p_yt;
  logic signed [EW-1:0]      e_xx;
  logic signed [EW-1:0]      e_xy;
  logic signed [EW-1:0]      e_yy;
  logic signed [EW-1:0]      e_xt;
  logic signed [EW-1:0]      e_yt;

  // Products of the popped entry, sign-extended before the low bits are kept.
  always_comb begin
    sx   = $signed(q_data[QDW-1 -: SW]);
    sy   = $signed(q_data[DW+SW-1 -: SW]);
    dt   = $signed(q_data[DW-1:0]);
    p_xx = sx * sx;
    p_xy = sx * sy;
    p_yy = sy * sy;
    p_xt = sx * dt;
    p_yt = sy * dt;
    e_xx = EW'(p_xx);
    e_xy = EW'(p_xy);
    e_yy = EW'(p_yy);
    e_xt = EW'(p_xt);
    e_yt = EW'(p_yt);
  end

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {PAD'(0),
                  e_yt[ofgp_pkg::YT_W-1:0],
                  e_xt[ofgp_pkg::XT_W-1:0],
                  e_yy[ofgp_pkg::YY_W-1:0],
                  e_xy[ofgp_pkg::XY_W-1:0],
                  e_xx[ofgp_pkg::XX_W-1:0]};
      m_tlast <= q_flags.frame_last;
      m_tuser <= q_flags.out_valid;
    end
  end

endmodule

/* rtl/optical_flow_gradient_products.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_flow_gradient_products: structure tensor terms for optical flow
// Takes pixel pairs of two co-registered frames in raster order and emits,
// for each pixel, the products xx, xy, yy (4 fractional bits) and xt, yt
// (2 fractional bits) of the averaged central differences.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata, one pixel pair per beat.
//   Every input beat yields exactly one result beat on m_tvalid/m_tready,
//   with m_tuser as the pixel-valid flag and m_tlast on the last result of
//   a frame. Results follow the raster one line plus one pixel behind the
//   input; border pixels give zero products, and the first line plus one
//   beats after reset give results with m_tuser low and all fields zero.
//   Throughput is one beat per clock while the receiver takes results. An
//   accepted beat passes the line store read into stage one, where the
//   differences are formed and pushed to the queue; the multipliers then
//   work on the queue head and load the output register, which presents
//   the result.
//   When the receiver stalls, the four-entry queue fills and s_tready falls
//   once the queue and the difference stage hold four beats.
//   Reset returns the geometry to 1024 x 1024, clears the raster position
//   and marks the line stores empty; no clearing pass is needed.
//   Geometry is written on cfg_we/cfg_index/cfg_data while no beat is in
//   flight.
// ----------------------------------------------------------------------------
module optical_flow_gradient_products #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ofgp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ofgp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // pix_first, pix_second
  input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // grad_xx, grad_xy, grad_yy, grad_xt, grad_yt, zero fill
  output logic [ofgp_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  // out_valid
  output logic                                 m_tuser
);

  localparam int unsigned IN_W = ((2 * PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned QDW  = 2 * (PIXEL_BITS + 2) + PIXEL_BITS + 1;
  localparam int unsigned FLW  = $bits(ofgp_pkg::ofgp_flags_t);

  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  logic [ofgp_pkg::QUEUE_AW:0]   q_count;
  ofgp_pkg::ofgp_flags_t         f_flags;
  logic [QDW-1:0]                f_data;
  logic [FLW+QDW-1:0]            q_rdata;

  // Front end: raster tracking, line stores and differences.
  ofgp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .IN_W       (IN_W),
    .QDW        (QDW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_flags   (f_flags),
    .q_data    (f_data)
  );

  // Queue between the two halves.
  ofgp_queue #(.WIDTH(FLW + QDW)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  ({f_flags, f_data}),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .rvalid (q_valid),
    .count  (q_count)
  );

  // Back end: products and output register.
  ofgp_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .QDW        (QDW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_flags  (ofgp_pkg::ofgp_flags_t'(q_rdata[FLW+QDW-1:QDW])),
    .q_data   (q_rdata[QDW-1:0]),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // The front end never pushes into a full queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> (32'(q_count) < ofgp_pkg::QUEUE_DEPTH))
    else $error("queue push while full");

  // The back end never pops an empty queue.
  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("queue pop while empty");

  // Every accepted beat reaches the queue in the following cycle.
  a_beat_reaches_queue : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_push)
    else $error("accepted beat lost before the queue");

  // A result that belongs to no pixel carries zeros only.
  a_invalid_is_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> ((m_tdata == '0) && !m_tlast))
    else $error("non-pixel result carries data");

endmodule
